FILE: rtl/hfbe_pkg.sv
// Package: shared types, constants and CRC helper for the HDLC bit encoder.
package hfbe_pkg;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_FLAG  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_FCS   = 2'd3
  } cmd_e;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [2:0]  STUFF_AFTER = 3'd5;
  localparam int          CntW        = 5;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/hdlc_frame_bit_encoder.sv
// Top level: HDLC transmit line encoder (flags, bit stuffing, CRC-16 FCS, NRZI).
// Path: input register, then the bit engine's shift register and output register.
// Throughput: one line bit per cycle unless back-pressured. Bits per item: flag 8,
// data 8-10, FCS 16-20, reset none. Next item loads while the last bit is emitted.
// Reset: line level 1, ones run 0, CRC 0xFFFF, no transaction pending.
module hdlc_frame_bit_encoder import hfbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] line_bit, [7:1] zero
  output logic       m_axis_tuser,   // [0] stuffed_bit
  output logic       m_axis_tlast    // last bit of the item
);

  item_t in_item, item;
  logic  item_valid, item_ready, line_bit;

  assign in_item.cmd  = cmd_e'(s_axis_tuser);
  assign in_item.data = s_axis_tdata;

  hfbe_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  hfbe_bit_engine u_bit_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_bit_o     (line_bit),
    .out_stuffed_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, line_bit};

endmodule

FILE: rtl/hfbe_in_reg.sv
// Input register: holds one accepted transaction until the bit engine takes it.
module hfbe_in_reg import hfbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  input  logic  item_ready_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/hfbe_bit_engine.sv
// Bit engine: serializes commands into stuffed NRZI line bits with a CRC and output register.
module hfbe_bit_engine import hfbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  item_t item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  out_bit_o,
  output logic  out_stuffed_o,
  output logic  out_last_o
);

  logic [15:0]   shreg_q, shreg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          stuffing_q, stuffing_d;
  logic          level_q, level_d;
  logic [2:0]    ones_q, ones_d;
  logic [15:0]   crc_q, crc_d;
  logic          ov_q, ov_d;
  logic          obit_q, ostuff_q, olast_q;

  logic pend, busy, out_free, emit, bit_v, stuffed_v, last_v, pend_n, eng_free, load;
  logic lvl_v;

  assign pend     = stuffing_q && (ones_q == STUFF_AFTER);
  assign busy     = (cnt_q != '0) || pend;
  assign out_free = !ov_q || out_ready_i;
  assign emit     = busy && out_free;

  always_comb begin
    shreg_d    = shreg_q;
    cnt_d      = cnt_q;
    stuffing_d = stuffing_q;
    level_d    = level_q;
    ones_d     = ones_q;
    crc_d      = crc_q;
    bit_v      = 1'b0;
    stuffed_v  = 1'b0;
    lvl_v      = level_q;
    if (emit) begin
      if (pend) begin
        bit_v     = 1'b0;
        stuffed_v = 1'b1;
        ones_d    = 3'd0;
      end else begin
        bit_v   = shreg_q[0];
        shreg_d = shreg_q >> 1;
        cnt_d   = cnt_q - CntW'(1);
        ones_d  = (stuffing_q && bit_v) ? ones_q + 3'd1 : 3'd0;
      end
      lvl_v   = bit_v ? level_q : ~level_q;
      level_d = lvl_v;
    end
    pend_n   = stuffing_q && (ones_d == STUFF_AFTER);
    last_v   = (cnt_d == '0) && !pend_n;
    eng_free = !busy || (emit && last_v);
    load     = item_valid_i && eng_free;
    if (load) begin
      unique case (item_i.cmd)
        CMD_RESET: begin
          level_d = 1'b1;
          ones_d  = 3'd0;
          crc_d   = CRC_INIT;
          cnt_d   = '0;
        end
        CMD_FLAG: begin
          shreg_d    = {8'h00, FLAG_BYTE};
          cnt_d      = CntW'(8);
          stuffing_d = 1'b0;
        end
        CMD_DATA: begin
          shreg_d    = {8'h00, item_i.data};
          cnt_d      = CntW'(8);
          stuffing_d = 1'b1;
          crc_d      = crc_fold(crc_q, item_i.data);
        end
        CMD_FCS: begin
          shreg_d    = ~crc_q;
          cnt_d      = CntW'(16);
          stuffing_d = 1'b1;
          crc_d      = CRC_INIT;
        end
        default: begin
          cnt_d = '0;
        end
      endcase
    end
    ov_d = out_free ? emit : ov_q;
  end

  assign item_ready_o = eng_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      stuffing_q <= 1'b0;
      level_q    <= 1'b1;
      ones_q     <= 3'd0;
      crc_q      <= CRC_INIT;
      ov_q       <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      stuffing_q <= stuffing_d;
      level_q    <= level_d;
      ones_q     <= ones_d;
      crc_q      <= crc_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    if (emit) begin
      obit_q   <= lvl_v;
      ostuff_q <= stuffed_v;
      olast_q  <= last_v;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_bit_o     = obit_q;
  assign out_stuffed_o = ostuff_q;
  assign out_last_o    = olast_q;

endmodule

FILE: tb/hdlc_frame_bit_encoder_checker.sv
// Checker: predicts the NRZI line bits of the HDLC encoder and compares each output transaction.
module hdlc_frame_bit_encoder_checker import hfbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_ready_i,
  input  logic [7:0] s_data_i,
  input  logic [1:0] s_user_i,
  input  logic       m_valid_i,
  input  logic       m_ready_i,
  input  logic [7:0] m_data_i,
  input  logic       m_user_i,
  input  logic       m_last_i,
  output int         err_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic line;
    logic stuffed;
    logic last;
  } line_bit_t;

  line_bit_t   expected_bits[$];
  logic        line_lvl;
  logic [2:0]  ones_cnt;
  logic [15:0] fcs_crc;
  int          mismatches;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  function automatic logic [15:0] crc_after_byte(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic emit_bit(input logic b, input logic stuffed);
    if (!b) begin
      line_lvl = ~line_lvl;
    end
    expected_bits.push_back('{line_lvl, stuffed, 1'b0});
  endtask

  task automatic shift_out_byte(input logic [7:0] b, input logic stuff_en);
    for (int i = 0; i < 8; i++) begin
      emit_bit(b[i], 1'b0);
      if (stuff_en && b[i]) begin
        ones_cnt = ones_cnt + 3'd1;
        if (ones_cnt >= STUFF_AFTER) begin
          emit_bit(1'b0, 1'b1);
          ones_cnt = '0;
        end
      end else begin
        ones_cnt = '0;
      end
    end
  endtask

  task automatic predict_item(input cmd_e cmd, input logic [7:0] b);
    logic [15:0] fcs;
    case (cmd)
      CMD_RESET: begin
        line_lvl = 1'b1;
        ones_cnt = '0;
        fcs_crc  = CRC_INIT;
      end
      CMD_FLAG: begin
        shift_out_byte(FLAG_BYTE, 1'b0);
      end
      CMD_DATA: begin
        shift_out_byte(b, 1'b1);
        fcs_crc = crc_after_byte(fcs_crc, b);
      end
      default: begin
        fcs = ~fcs_crc;
        shift_out_byte(fcs[7:0], 1'b1);
        shift_out_byte(fcs[15:8], 1'b1);
        fcs_crc = CRC_INIT;
      end
    endcase
    if (cmd != CMD_RESET) begin
      expected_bits[expected_bits.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: got tdata=%02h tuser=%0b tlast=%0b", $time, what,
               m_data_i, m_user_i, m_last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_bit_t exp_bit;
    if (!rst_ni) begin
      expected_bits.delete();
      line_lvl   = 1'b1;
      ones_cnt   = '0;
      fcs_crc    = CRC_INIT;
      mismatches = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        predict_item(cmd_e'(s_user_i), s_data_i);
      end
      if (m_valid_i && m_ready_i) begin
        if (expected_bits.size() == 0) begin
          report_mismatch("unexpected transaction");
        end else begin
          exp_bit = expected_bits.pop_front();
          if (m_data_i !== {7'd0, exp_bit.line} || m_user_i !== exp_bit.stuffed ||
              m_last_i !== exp_bit.last) begin
            report_mismatch($sformatf("expected tdata=%02h tuser=%0b tlast=%0b",
                                      {7'd0, exp_bit.line}, exp_bit.stuffed, exp_bit.last));
          end
        end
      end
    end
    err_count_o <= mismatches;
    pending_o   <= expected_bits.size();
  end

endmodule

FILE: tb/hdlc_frame_bit_encoder_tb.sv
// Testbench top: drives command/byte stimulus with random gaps and back-pressure, reports verdict.
module hdlc_frame_bit_encoder_tb import hfbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int ITEM_TARGET    = 310;
  localparam int DRAIN_CYCLES   = 10;
  localparam int TIMEOUT_CYCLES = 200_000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] data_byte
  logic [1:0] s_axis_tuser  = '0;   // [1:0] cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [0] line_bit, [7:1] zero
  logic       m_axis_tuser;         // [0] stuffed_bit
  logic       m_axis_tlast;
  logic       quiet         = 1'b0;
  int         sent_count    = 0;
  int         err_count;
  int         pending;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hdlc_frame_bit_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hdlc_frame_bit_encoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .m_last_i    (m_axis_tlast),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 33);
  end

  task automatic send_item(input cmd_e cmd, input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 2'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // hold the input off until every line bit has come out
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_frame();
    int         n_bytes;
    logic [7:0] b;
    n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
    repeat ($urandom_range(1, 2)) send_item(CMD_FLAG, 8'($urandom));
    for (int k = 0; k < n_bytes; k++) begin
      case ($urandom_range(0, 5))
        0:       b = 8'hFF;
        1:       b = 8'hF8 | 8'($urandom_range(0, 7));
        default: b = 8'($urandom);
      endcase
      send_item(CMD_DATA, b);
    end
    // occasionally abort the frame without its FCS
    if ($urandom_range(0, 19) != 0) begin
      send_item(CMD_FCS, 8'($urandom));
    end
    send_item(CMD_FLAG, 8'($urandom));
  endtask

  initial begin
    int  pick;
    logic paused;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_FLAG, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h7E);
    send_item(CMD_FCS, 8'hA5);
    send_item(CMD_FLAG, 8'h00);
    send_item(CMD_FCS, 8'hFF);      // empty frame: CRC still at init
    send_item(CMD_DATA, 8'h1F);
    send_item(CMD_RESET, 8'hFF);    // resets line level, ones run and CRC
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'hF8);
    send_item(CMD_DATA, 8'hFF);     // no run carried in, one stuffing zero
    send_item(CMD_DATA, 8'h0F);
    send_item(CMD_DATA, 8'h55);
    send_item(CMD_FCS, 8'h00);
    send_item(CMD_FLAG, 8'h3C);
    send_item(CMD_RESET, 8'h00);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_FLAG, 8'h81);
    send_item(CMD_RESET, 8'h5A);
    drain_outputs();

    while (sent_count < ITEM_TARGET) begin
      quiet = (sent_count >= 120 && sent_count < 180);
      pick  = $urandom_range(0, 99);
      if (pick < 80) begin
        send_frame();
      end else if (pick < 88) begin
        send_item(CMD_RESET, 8'($urandom));
      end else begin
        send_item(cmd_e'($urandom_range(0, 3)), 8'($urandom));
      end
      if (!paused && sent_count >= 220) begin
        paused = 1'b1;
        drain_outputs();
      end
    end
    quiet = 1'b0;
    drain_outputs();

    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
